@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the tour segment reversal rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define TSR_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define TSR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/tsr_pkg.sv @@
// shared types and constants of the tour segment reversal block
package tsr_pkg;

   localparam int TSR_MAX_CITIES = 64;

   localparam int FUNC_W = 2;
   localparam int POS_W  = 6;
   localparam int CITY_W = 6;
   localparam int CFG_W  = 7;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INVERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   typedef enum logic {
      ALU_INC = 1'b0,
      ALU_DEC = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic wrap;
      logic equal;
   } alu_flags_type;

endpackage

@@ rtl/core/tsr_req_if.sv @@
// request channel: operation and its operands
interface tsr_req_if import tsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  position;
   logic [CITY_W-1:0] city;
   logic [CITY_W-1:0] city_first;
   logic [CITY_W-1:0] city_last;

   modport source (output valid, func, position, city, city_first, city_last, input ready);
   modport sink (input valid, func, position, city, city_first, city_last, output ready);
endinterface

@@ rtl/core/tsr_rsp_if.sv @@
// response channel: read city and rejected flag
interface tsr_rsp_if import tsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CITY_W-1:0] city_out;
   logic              rejected;

   modport source (output valid, city_out, rejected, input ready);
   modport sink (input valid, city_out, rejected, output ready);
endinterface

@@ rtl/core/tsr_csr_if.sv @@
// register write channel for the tour size
interface tsr_csr_if import tsr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/tsr_ram.sv @@
// generic single-port ram with registered read
module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/tsr_alu.sv @@
// shared cyclic position step unit with compare
module tsr_alu import tsr_pkg::*; #(
   parameter int POS_W_INT = 6
) (
   input  alu_op_type           op,
   input  logic [POS_W_INT-1:0] opnd,
   input  logic [POS_W_INT-1:0] last,
   input  logic [POS_W_INT-1:0] cmp_x,
   input  logic [POS_W_INT-1:0] cmp_y,
   output logic [POS_W_INT-1:0] result,
   output alu_flags_type        flags
);

   always_comb begin
      flags.equal = (cmp_x == cmp_y);
      unique case (op)
         ALU_INC: begin
            flags.wrap = (opnd == last);
            result     = flags.wrap ? '0 : opnd + POS_W_INT'(1);
         end
         ALU_DEC: begin
            flags.wrap = (opnd == '0);
            result     = flags.wrap ? last : opnd - POS_W_INT'(1);
         end
         default: begin
            flags.wrap = 1'b0;
            result     = opnd;
         end
      endcase
   end

endmodule

@@ rtl/core/tour_segment_reversal.sv @@
// top level: tour store with read, write and cyclic segment reversal
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    func, position, city, city_first, city_last
//   rsp_if   out  valid/ready    city_out, rejected
//   csr_if   in   valid/ready    data (cities_in_use)
//
// from transfer, a write passes through the done state and a read through read-wait and done to the response register
// invert: scan, scan tail and setup states, then check, read-e, write-s and write-e per swapped pair,
//   then the done state to the response register; an odd segment ends from check, an even one from write-e
// one ram port sets the pace: every scan step and every swap access uses it
// no clearing pass after reset; csr writes are taken in every cycle
// a stalled response holds the done state, req_if.ready stays low until idle
`include "assert_macros.svh"

module tour_segment_reversal import tsr_pkg::*; #(
   parameter int MAX_CITIES = TSR_MAX_CITIES
) (
   input  logic      clock,
   input  logic      reset,
   tsr_req_if.sink   req_if,
   tsr_rsp_if.source rsp_if,
   tsr_csr_if.sink   csr_if
);

   localparam int AW = $clog2(MAX_CITIES);
   localparam int NW = $clog2(MAX_CITIES + 1);
   localparam int CW = (NW > CFG_W) ? NW : CFG_W;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_RD_WAIT   = 10'b0000000010,
      ST_SCAN      = 10'b0000000100,
      ST_SCAN_TAIL = 10'b0000001000,
      ST_SETUP     = 10'b0000010000,
      ST_CHECK     = 10'b0000100000,
      ST_RD_E      = 10'b0001000000,
      ST_WR_S      = 10'b0010000000,
      ST_WR_E      = 10'b0100000000,
      ST_DONE      = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  cfg_ff, cfg_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CITY_W-1:0] ca_ff, ca_in;
   logic [CITY_W-1:0] cb_ff, cb_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              found_a_ff, found_a_in;
   logic              found_b_ff, found_b_in;
   logic [AW-1:0]     apos_ff, apos_in;
   logic [AW-1:0]     s_ff, s_in;
   logic [AW-1:0]     e_ff, e_in;
   logic [AW-1:0]     nxt_ff, nxt_in;
   logic [CITY_W-1:0] tmp_ff, tmp_in;
   logic [CITY_W-1:0] res_city_ff, res_city_in;
   logic              res_rej_ff, res_rej_in;
   logic [CITY_W-1:0] rsp_city_ff, rsp_city_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic [CW-1:0]     cfg_ext;
   logic [CW-1:0]     max_ext;
   logic [CW-1:0]     n_ext;
   logic [AW-1:0]     last_pos;
   logic              pos_ok;
   logic [AW-1:0]     pos_addr;
   logic              out_free;
   logic              st_done;
   logic              wr_state;

   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [CITY_W-1:0] ram_wdata;
   logic [CITY_W-1:0] ram_rdata;

   alu_op_type        alu_op;
   logic [AW-1:0]     alu_opnd;
   logic [AW-1:0]     alu_cmp_x;
   logic [AW-1:0]     alu_cmp_y;
   logic [AW-1:0]     alu_result;
   alu_flags_type     alu_flags;

   tsr_ram #(
      .WIDTH (CITY_W),
      .DEPTH (MAX_CITIES)
   ) u_tour_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   tsr_alu #(
      .POS_W_INT (AW)
   ) u_alu (
      .op     (alu_op),
      .opnd   (alu_opnd),
      .last   (last_pos),
      .cmp_x  (alu_cmp_x),
      .cmp_y  (alu_cmp_y),
      .result (alu_result),
      .flags  (alu_flags)
   );

   // tour size saturated to 2 .. MAX_CITIES
   assign cfg_ext  = CW'(cfg_ff);
   assign max_ext  = CW'(MAX_CITIES);
   assign n_ext    = (cfg_ext < CW'(2)) ? CW'(2) : ((cfg_ext > max_ext) ? max_ext : cfg_ext);
   assign last_pos = AW'(n_ext - CW'(1));
   assign pos_ok   = (CW'(req_if.position) < n_ext);
   assign pos_addr = AW'(req_if.position);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign st_done  = (state_ff == ST_DONE);
   assign wr_state = (state_ff == ST_IDLE) || (state_ff == ST_WR_S) || (state_ff == ST_WR_E);

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign csr_if.ready    = 1'b1;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.city_out = rsp_city_ff;
   assign rsp_if.rejected = rsp_rej_ff;

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      rd_vld_in    = (state_ff == ST_SCAN);
      rsp_valid_in = rsp_valid_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      idx_in       = idx_ff;
      rd_idx_in    = idx_ff;
      found_a_in   = found_a_ff;
      found_b_in   = found_b_ff;
      apos_in      = apos_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      nxt_in       = nxt_ff;
      tmp_in       = tmp_ff;
      res_city_in  = res_city_ff;
      res_rej_in   = res_rej_ff;
      rsp_city_in  = rsp_city_ff;
      rsp_rej_in   = rsp_rej_ff;
      ram_we       = 1'b0;
      ram_addr     = idx_ff;
      ram_wdata    = ram_rdata;
      alu_op       = ALU_INC;
      alu_opnd     = idx_ff;
      alu_cmp_x    = s_ff;
      alu_cmp_y    = e_ff;

      if (csr_if.valid) begin
         cfg_in = csr_if.data;
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // scan compare, last match wins
      if (rd_vld_ff) begin
         if (ram_rdata == ca_ff) begin
            found_a_in = 1'b1;
            apos_in    = rd_idx_ff;
         end
         if (ram_rdata == cb_ff) begin
            found_b_in = 1'b1;
            e_in       = rd_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               ca_in       = req_if.city_first;
               cb_in       = req_if.city_last;
               idx_in      = '0;
               found_a_in  = 1'b0;
               found_b_in  = 1'b0;
               res_city_in = '0;
               res_rej_in  = 1'b0;
               unique case (req_if.func)
                  FUNC_WRITE: begin
                     if (pos_ok) begin
                        ram_we    = 1'b1;
                        ram_addr  = pos_addr;
                        ram_wdata = req_if.city;
                     end else begin
                        res_rej_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  FUNC_INVERT: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_READ: begin
                     if (pos_ok) begin
                        ram_addr = pos_addr;
                        state_in = ST_RD_WAIT;
                     end else begin
                        res_rej_in = 1'b1;
                        state_in   = ST_DONE;
                     end
                  end
                  default: begin
                     res_rej_in = 1'b1;
                     state_in   = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_city_in = ram_rdata;
            state_in    = ST_DONE;
         end
         ST_SCAN: begin
            ram_addr = idx_ff;
            alu_op   = ALU_INC;
            alu_opnd = idx_ff;
            idx_in   = alu_result;
            if (alu_flags.wrap) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (!(found_a_ff && found_b_ff)) begin
               res_rej_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               alu_op   = ALU_INC;
               alu_opnd = apos_ff;
               s_in     = alu_result;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            alu_cmp_x = s_ff;
            alu_cmp_y = e_ff;
            if (alu_flags.equal) begin
               state_in = ST_DONE;
            end else begin
               ram_addr = s_ff;
               state_in = ST_RD_E;
            end
         end
         ST_RD_E: begin
            ram_addr = e_ff;
            tmp_in   = ram_rdata;
            state_in = ST_WR_S;
         end
         ST_WR_S: begin
            ram_we    = 1'b1;
            ram_addr  = s_ff;
            ram_wdata = ram_rdata;
            alu_op    = ALU_INC;
            alu_opnd  = s_ff;
            nxt_in    = alu_result;
            state_in  = ST_WR_E;
         end
         ST_WR_E: begin
            ram_we    = 1'b1;
            ram_addr  = e_ff;
            ram_wdata = tmp_ff;
            alu_cmp_x = nxt_ff;
            alu_cmp_y = e_ff;
            alu_op    = ALU_DEC;
            alu_opnd  = e_ff;
            if (alu_flags.equal) begin
               state_in = ST_DONE;
            end else begin
               s_in     = nxt_ff;
               e_in     = alu_result;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_city_in  = res_city_ff;
               rsp_rej_in   = res_rej_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      found_a_ff  <= found_a_in;
      found_b_ff  <= found_b_in;
      apos_ff     <= apos_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      nxt_ff      <= nxt_in;
      tmp_ff      <= tmp_in;
      res_city_ff <= res_city_in;
      res_rej_ff  <= res_rej_in;
      rsp_city_ff <= rsp_city_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   `TSR_ASSERT_IMP(a_write_in_range, ram_we, ram_addr <= last_pos, "ram write beyond tour")
   `TSR_ASSERT_IMP(a_write_states, ram_we, wr_state, "ram write outside write states")
   `TSR_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(st_done), "stray response")
   `TSR_ASSERT_NEXT(a_done_holds, st_done && !out_free, st_done, "result lost")

endmodule
